>>> src/ptca_pkg.sv
`default_nettype none
package ptca_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int ID_W          = 22;
    localparam int THR_W         = 32;
    localparam int CNT_W         = 64;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [ID_W-1:0]  id_t;

    typedef enum logic [1:0] {
        CMD_SWITCH = 2'd0,
        CMD_FORK   = 2'd1,
        CMD_EXIT   = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MODIFY,
        ST_WR_S,
        ST_WR_T,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic             valid;
        id_t              key;
        logic [CNT_W-1:0] cpu_time;
        logic [CNT_W-1:0] voluntary;
        logic [CNT_W-1:0] involuntary;
        logic [THR_W-1:0] threads;
        logic [CNT_W-1:0] last_start;
        id_t              group_tag;
    } entry_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [CNT_W-1:0] time_ns;
        id_t              first_id;
        id_t              second_id;
        logic             prev_still_runnable;
        id_t              caller_group;
    } item_t;

    typedef struct packed {
        cmd_t             event_kind;
        id_t              group_id;
        id_t              thread_id;
        logic [CNT_W-1:0] timestamp;
        logic             entry_found;
        logic [CNT_W-1:0] cpu_time_ns;
        logic [CNT_W-1:0] voluntary_count;
        logic [CNT_W-1:0] involuntary_count;
        logic [THR_W-1:0] live_threads;
        id_t              entry_group;
        logic             table_full;
    } result_t;

    typedef struct packed {
        logic   we;
        idx_t   waddr;
        entry_t wdata;
        logic   re;
        idx_t   raddr;
    } mem_req_t;

endpackage
`default_nettype wire

>>> src/ptca_ram.sv
`default_nettype none
module ptca_ram (
    input  wire logic              clk,
    input  wire ptca_pkg::mem_req_t req,
    output ptca_pkg::entry_t       rdata
);
    import ptca_pkg::*;

    entry_t mem [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule
`default_nettype wire

>>> src/ptca_ctrl.sv
`default_nettype none
module ptca_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ptca_pkg::item_t    in_item,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output ptca_pkg::result_t       res,
    output ptca_pkg::mem_req_t      mem_req,
    input  wire ptca_pkg::entry_t   mem_rdata
);
    import ptca_pkg::*;

    localparam logic [IDX_W:0] CNT_END = (IDX_W+1)'(TABLE_ENTRIES);

    state_t         state_reg, state_next;
    logic [IDX_W:0] cnt_reg, cnt_next;
    logic           rd_pend_reg, rd_pend_next;
    idx_t           rd_addr_reg, rd_addr_next;
    item_t          item_reg, item_next;
    logic           s_hit_reg, s_hit_next, t_hit_reg, t_hit_next;
    logic           free_hit_reg, free_hit_next;
    idx_t           s_idx_reg, s_idx_next, t_idx_reg, t_idx_next;
    idx_t           free_idx_reg, free_idx_next;
    entry_t         rec_s_reg, rec_s_next, rec_t_reg, rec_t_next;
    entry_t         wr_s_reg, wr_s_next, wr_t_reg, wr_t_next;
    idx_t           t_addr_reg, t_addr_next;
    logic           do_s_reg, do_s_next, do_t_reg, do_t_next;
    result_t        res_reg, res_next;

    // combinational update terms
    entry_t s_mod, t_base, t_mod, fresh;
    logic   same_id;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= rd_addr_next;
        item_reg     <= item_next;
        s_hit_reg    <= s_hit_next;
        t_hit_reg    <= t_hit_next;
        free_hit_reg <= free_hit_next;
        s_idx_reg    <= s_idx_next;
        t_idx_reg    <= t_idx_next;
        free_idx_reg <= free_idx_next;
        rec_s_reg    <= rec_s_next;
        rec_t_reg    <= rec_t_next;
        wr_s_reg     <= wr_s_next;
        wr_t_reg     <= wr_t_next;
        t_addr_reg   <= t_addr_next;
        do_s_reg     <= do_s_next;
        do_t_reg     <= do_t_next;
        res_reg      <= res_next;
    end

    // record updates for the event held in item_reg
    always_comb
    begin
        same_id = (item_reg.first_id == item_reg.second_id);
        s_mod   = rec_s_reg;
        fresh   = '0;
        fresh.valid      = 1'b1;
        fresh.key        = item_reg.second_id;
        case (item_reg.cmd)
            CMD_SWITCH:
            begin
                if (rec_s_reg.last_start != '0)
                begin
                    s_mod.cpu_time   = rec_s_reg.cpu_time + (item_reg.time_ns
                                       - rec_s_reg.last_start);
                    s_mod.last_start = '0;
                    if (item_reg.prev_still_runnable)
                        s_mod.involuntary = rec_s_reg.involuntary + 1'b1;
                    else
                        s_mod.voluntary = rec_s_reg.voluntary + 1'b1;
                end
                fresh.last_start = item_reg.time_ns;
            end
            CMD_FORK:
            begin
                s_mod.threads   = rec_s_reg.threads + 1'b1;
                fresh.group_tag = item_reg.caller_group;
            end
            CMD_EXIT:
            begin
                if (rec_s_reg.threads != '0)
                    s_mod.threads = rec_s_reg.threads - 1'b1;
                if (t_hit_reg && !same_id)
                begin
                    s_mod.cpu_time    = rec_s_reg.cpu_time + rec_t_reg.cpu_time;
                    s_mod.voluntary   = rec_s_reg.voluntary + rec_t_reg.voluntary;
                    s_mod.involuntary = rec_s_reg.involuntary
                                        + rec_t_reg.involuntary;
                end
            end
            default:
            begin
                s_mod = rec_s_reg;
            end
        endcase
        // same slot on both sides: the second step sees the first one's result
        t_base = (s_hit_reg && t_hit_reg && same_id) ? s_mod : rec_t_reg;
        t_mod  = t_base;
        case (item_reg.cmd)
            CMD_SWITCH: t_mod.last_start = item_reg.time_ns;
            CMD_EXIT:   t_mod.valid      = 1'b0;
            default:    t_mod            = t_base;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rd_pend_next  = 1'b0;
        rd_addr_next  = rd_addr_reg;
        item_next     = item_reg;
        s_hit_next    = s_hit_reg;
        t_hit_next    = t_hit_reg;
        free_hit_next = free_hit_reg;
        s_idx_next    = s_idx_reg;
        t_idx_next    = t_idx_reg;
        free_idx_next = free_idx_reg;
        rec_s_next    = rec_s_reg;
        rec_t_next    = rec_t_reg;
        wr_s_next     = wr_s_reg;
        wr_t_next     = wr_t_reg;
        t_addr_next   = t_addr_reg;
        do_s_next     = do_s_reg;
        do_t_next     = do_t_reg;
        res_next      = res_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mem_req       = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_reg[IDX_W-1:0];
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_END - 1'b1)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next     = in_item;
                    cnt_next      = '0;
                    s_hit_next    = 1'b0;
                    t_hit_next    = 1'b0;
                    free_hit_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg != CNT_END)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = cnt_reg[IDX_W-1:0];
                    rd_pend_next  = 1'b1;
                    rd_addr_next  = cnt_reg[IDX_W-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
                if (rd_pend_reg)
                begin
                    if (mem_rdata.valid && mem_rdata.key == item_reg.first_id)
                    begin
                        s_hit_next = 1'b1;
                        s_idx_next = rd_addr_reg;
                        rec_s_next = mem_rdata;
                    end
                    if (mem_rdata.valid && mem_rdata.key == item_reg.second_id)
                    begin
                        t_hit_next = 1'b1;
                        t_idx_next = rd_addr_reg;
                        rec_t_next = mem_rdata;
                    end
                    if (!mem_rdata.valid && !free_hit_reg)
                    begin
                        free_hit_next = 1'b1;
                        free_idx_next = rd_addr_reg;
                    end
                end
                if (cnt_reg == CNT_END && !rd_pend_reg)
                    state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                wr_s_next   = s_mod;
                do_s_next   = 1'b0;
                do_t_next   = 1'b0;
                t_addr_next = t_idx_reg;
                wr_t_next   = t_mod;
                res_next    = '0;
                res_next.event_kind = item_reg.cmd;
                case (item_reg.cmd)
                    CMD_SWITCH:
                    begin
                        do_s_next = s_hit_reg && (rec_s_reg.last_start != '0);
                        if (t_hit_reg)
                            do_t_next = 1'b1;
                        else if (free_hit_reg)
                        begin
                            do_t_next   = 1'b1;
                            t_addr_next = free_idx_reg;
                            wr_t_next   = fresh;
                        end
                        else
                            res_next.table_full = 1'b1;
                    end
                    CMD_FORK:
                    begin
                        do_s_next = s_hit_reg;
                        if (!t_hit_reg)
                        begin
                            if (free_hit_reg)
                            begin
                                do_t_next   = 1'b1;
                                t_addr_next = free_idx_reg;
                                wr_t_next   = fresh;
                            end
                            else
                                res_next.table_full = 1'b1;
                        end
                        res_next.group_id  = item_reg.first_id;
                        res_next.thread_id = item_reg.second_id;
                        res_next.timestamp = item_reg.time_ns;
                    end
                    CMD_EXIT:
                    begin
                        do_s_next          = s_hit_reg;
                        do_t_next          = t_hit_reg;
                        res_next.group_id  = item_reg.first_id;
                        res_next.thread_id = item_reg.second_id;
                        res_next.timestamp = item_reg.time_ns;
                    end
                    default:
                    begin
                        res_next.thread_id = item_reg.first_id;
                        if (s_hit_reg)
                        begin
                            res_next.entry_found       = 1'b1;
                            res_next.cpu_time_ns       = rec_s_reg.cpu_time;
                            res_next.voluntary_count   = rec_s_reg.voluntary;
                            res_next.involuntary_count = rec_s_reg.involuntary;
                            res_next.live_threads      = rec_s_reg.threads;
                            res_next.entry_group       = rec_s_reg.group_tag;
                        end
                    end
                endcase
                state_next = ST_WR_S;
            end
            ST_WR_S:
            begin
                mem_req.we    = do_s_reg;
                mem_req.waddr = s_idx_reg;
                mem_req.wdata = wr_s_reg;
                state_next    = ST_WR_T;
            end
            ST_WR_T:
            begin
                mem_req.we    = do_t_reg;
                mem_req.waddr = t_addr_reg;
                mem_req.wdata = wr_t_reg;
                state_next    = ST_RESULT;
            end
            ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign res = res_reg;

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_SCAN) |-> !mem_req.we)
        else $error("table written outside clear or write-back");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_SCAN && cnt_reg == '0))
        else $error("accepted event did not start a scan");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.re |-> (state_reg == ST_SCAN && !mem_req.we))
        else $error("table read outside scan");

endmodule
`default_nettype wire

>>> src/per_thread_cpu_accounting_table_core.sv
`default_nettype none
// Per-thread CPU accounting table. Holds up to TABLE_ENTRIES records keyed by a
// 22-bit thread id in one single-port-write synchronous memory. Every event
// (switch, fork, exit, read) is taken one at a time: a full sweep of the table
// finds the outgoing/parent/leader record, the incoming/child/exiting record
// and the first free slot, then the block modifies and writes back at most two
// records. No new event is taken until the current one has been swept, written
// back and its result handed on, and the sweep reads one entry per cycle from
// the memory. After reset a clearing pass empties the table; no event is
// accepted until it ends. One result transfer per event leaves through an
// output register, so the next event may be taken while a result waits.
module per_thread_cpu_accounting_table_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [63:0] time_ns, [85:64] first_id, [107:86] second_id,
    // [108] prev_still_runnable, [130:109] caller_group, [135:131] zero
    input  wire logic [135:0] s_axis_tdata,
    // [1:0] cmd
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [21:0] group_id, [43:22] thread_id, [107:44] timestamp, [108] entry_found,
    // [172:109] cpu_time_ns, [236:173] voluntary_count,
    // [300:237] involuntary_count, [332:301] live_threads,
    // [354:333] entry_group, [355] table_full, [359:356] zero
    output logic [359:0]      m_axis_tdata,
    // [1:0] event_kind
    output logic [1:0]        m_axis_tuser
);
    import ptca_pkg::*;

    item_t    in_item;
    result_t  res;
    logic     res_valid, res_ready;
    mem_req_t mem_req;
    entry_t   mem_rdata;
    logic     out_valid_reg, out_valid_next;
    result_t  out_reg, out_next;

    always_comb
    begin
        in_item.cmd                 = cmd_t'(s_axis_tuser);
        in_item.time_ns             = s_axis_tdata[63:0];
        in_item.first_id            = s_axis_tdata[85:64];
        in_item.second_id           = s_axis_tdata[107:86];
        in_item.prev_still_runnable = s_axis_tdata[108];
        in_item.caller_group        = s_axis_tdata[130:109];
    end

    ptca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    ptca_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // output register: takes a result when empty or when being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.event_kind;
    assign m_axis_tdata  = {4'b0, out_reg.table_full, out_reg.entry_group,
                            out_reg.live_threads, out_reg.involuntary_count,
                            out_reg.voluntary_count, out_reg.cpu_time_ns,
                            out_reg.entry_found, out_reg.timestamp,
                            out_reg.thread_id, out_reg.group_id};

endmodule
`default_nettype wire
